>>> rtl/core/mmbf_pkg.sv
// Shared constants, types and codes for the median / trimmed-mean blend filter.
package mmbf_pkg;

    // Window geometry
    localparam int WINDOW   = 10;
    localparam int TRIM     = 3;
    localparam int TRIM_EFF = (2 * TRIM >= WINDOW) ? (WINDOW - 1) / 2 : TRIM;
    localparam int KEPT     = WINDOW - 2 * TRIM_EFF;
    localparam int MEDIAN_IDX = WINDOW / 2;
    localparam int IDX_W    = $clog2(WINDOW);

    // Field widths
    localparam int SAMPLE_W  = 16;
    localparam int CH_W      = 2;
    localparam int WEIGHT_W  = 7;
    localparam int CFG_IDX_W = 2;

    // Arithmetic widths
    localparam int SUM_W   = $clog2(WINDOW * 65535 + 1);
    localparam int BLEND_W = SAMPLE_W + WEIGHT_W + 1;
    localparam int MUL_W   = (SUM_W + 1 > BLEND_W + 1) ? SUM_W + 1 : BLEND_W + 1;
    localparam int ACC_W   = 2 * MUL_W;

    // Division by KEPT as multiply by rounded-up reciprocal and shift
    localparam int MEAN_SHIFT = SUM_W + $clog2(KEPT);
    localparam logic [MUL_W-1:0] MEAN_RECIP =
        MUL_W'(((longint'(1) << MEAN_SHIFT) + longint'(KEPT) - 1) / longint'(KEPT));

    // Division by the weight scale the same way
    localparam int WEIGHT_SCALE = 100;
    localparam int Q_SHIFT = BLEND_W + $clog2(WEIGHT_SCALE);
    localparam logic [MUL_W-1:0] Q_RECIP =
        MUL_W'(((longint'(1) << Q_SHIFT) + longint'(WEIGHT_SCALE) - 1)
               / longint'(WEIGHT_SCALE));

    // Register indexes and reset values
    localparam logic [CFG_IDX_W-1:0] REG_MEAN_WEIGHT   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_MEDIAN_WEIGHT = CFG_IDX_W'(1);
    localparam logic [WEIGHT_W-1:0]  WEIGHT_RESET      = WEIGHT_W'(50);

    // Channel codes
    localparam logic [CH_W-1:0] CH_BANK1 = CH_W'(1);
    localparam logic [CH_W-1:0] CH_BANK2 = CH_W'(2);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SORT,
        ST_SUM,
        ST_MEAN,
        ST_WMEAN,
        ST_WMED,
        ST_QUOT,
        ST_FINISH
    } state_t;

    typedef enum logic [2:0] {
        OP_HOLD,
        OP_CLR,
        OP_ADD,
        OP_MUL,
        OP_MAC
    } arith_op_t;

    typedef struct packed {
        arith_op_t        op;
        logic [MUL_W-1:0] opa;
        logic [MUL_W-1:0] opb;
    } arith_cmd_t;

    typedef struct packed {
        logic             shift_en;
        logic             shift_bank;
        logic             rd_bank;
        logic [IDX_W-1:0] rd_idx;
    } win_ctrl_t;

    typedef struct packed {
        logic             init;
        logic             insert_en;
        logic [IDX_W-1:0] rd_idx;
    } sort_ctrl_t;

endpackage

>>> rtl/core/mmbf_window_bank.sv
// Two sliding sample windows, one per channel, with a single indexed read port.
module mmbf_window_bank
    import mmbf_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  win_ctrl_t           ctrl,
    input  logic [SAMPLE_W-1:0] sample_in,
    output logic [SAMPLE_W-1:0] rd_data
);

    logic [SAMPLE_W-1:0] win0_reg [WINDOW];
    logic [SAMPLE_W-1:0] win1_reg [WINDOW];

    // Shift the selected window: drop the oldest, append the new sample
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < WINDOW; i++)
            begin
                win0_reg[i] <= '0;
                win1_reg[i] <= '0;
            end
        end
        else if (ctrl.shift_en)
        begin
            if (!ctrl.shift_bank)
            begin
                for (int i = 0; i < WINDOW - 1; i++)
                begin
                    win0_reg[i] <= win0_reg[i+1];
                end
                win0_reg[WINDOW-1] <= sample_in;
            end
            else
            begin
                for (int i = 0; i < WINDOW - 1; i++)
                begin
                    win1_reg[i] <= win1_reg[i+1];
                end
                win1_reg[WINDOW-1] <= sample_in;
            end
        end
    end

    // Select one entry of the active window
    assign rd_data = ctrl.rd_bank ? win1_reg[ctrl.rd_idx] : win0_reg[ctrl.rd_idx];

endmodule

>>> rtl/core/mmbf_sort_array.sv
// Insertion sort array: takes one value per cycle while insert_en is set and keeps its entries ascending.
module mmbf_sort_array
    import mmbf_pkg::*;
(
    input  logic                clk,
    input  sort_ctrl_t          ctrl,
    input  logic [SAMPLE_W-1:0] insert_data,
    output logic [SAMPLE_W-1:0] rd_data,
    output logic [SAMPLE_W-1:0] median
);

    logic [SAMPLE_W-1:0] srt_reg  [WINDOW];
    logic [SAMPLE_W-1:0] srt_next [WINDOW];

    // Each cell keeps its value, takes the new one, or takes its lower neighbor's
    always_comb
    begin
        for (int j = 0; j < WINDOW; j++)
        begin
            if (srt_reg[j] <= insert_data)
            begin
                srt_next[j] = srt_reg[j];
            end
            else if (j == 0)
            begin
                srt_next[j] = insert_data;
            end
            else if (srt_reg[j-1] <= insert_data)
            begin
                srt_next[j] = insert_data;
            end
            else
            begin
                srt_next[j] = srt_reg[j-1];
            end
        end
    end

    // Fill with the top sentinel at start, then insert
    always_ff @(posedge clk)
    begin
        if (ctrl.init)
        begin
            for (int j = 0; j < WINDOW; j++)
            begin
                srt_reg[j] <= '1;
            end
        end
        else if (ctrl.insert_en)
        begin
            for (int j = 0; j < WINDOW; j++)
            begin
                srt_reg[j] <= srt_next[j];
            end
        end
    end

    assign rd_data = srt_reg[ctrl.rd_idx];
    assign median  = srt_reg[MEDIAN_IDX];

endmodule

>>> rtl/core/mmbf_arith_unit.sv
// Shared multiply / add unit with one accumulator register.
module mmbf_arith_unit
    import mmbf_pkg::*;
(
    input  logic             clk,
    input  arith_cmd_t       cmd,
    output logic [ACC_W-1:0] acc
);

    logic [ACC_W-1:0] acc_reg;
    logic [ACC_W-1:0] acc_next;
    logic [ACC_W-1:0] product;

    assign product = ACC_W'(cmd.opa) * ACC_W'(cmd.opb);

    // Pick the operation for this step
    always_comb
    begin
        case (cmd.op)
            OP_CLR:  acc_next = '0;
            OP_ADD:  acc_next = acc_reg + ACC_W'(cmd.opa);
            OP_MUL:  acc_next = product;
            OP_MAC:  acc_next = acc_reg + product;
            default: acc_next = acc_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
    end

    assign acc = acc_reg;

endmodule

>>> rtl/core/median_mean_blend_filter.sv
// Each item runs through one insertion per window entry, one shared add per kept entry and
// four passes through the shared multiplier before out_valid; a channel other than 1 or 2
// skips these and gives a zero result. A new item is accepted only after the last result is
// registered for output.
// Reset (async, active low) clears both windows, sets both weights to 50, empties output.
module median_mean_blend_filter
    import mmbf_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [SAMPLE_W-1:0]  sample,
    input  logic [CH_W-1:0]      channel,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [SAMPLE_W-1:0]  filtered,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [WEIGHT_W-1:0]  cfg_data
);

    state_t               state_reg, state_next;
    logic [IDX_W-1:0]     idx_reg, idx_next;
    logic                 bank_reg, bank_next;
    logic                 zero_reg, zero_next;
    logic                 out_valid_reg, out_valid_next;
    logic [SAMPLE_W-1:0]  filtered_reg, filtered_next;
    logic [WEIGHT_W-1:0]  mean_weight_reg;
    logic [WEIGHT_W-1:0]  median_weight_reg;

    win_ctrl_t            win_ctrl;
    sort_ctrl_t           sort_ctrl;
    arith_cmd_t           arith_cmd;
    logic [SAMPLE_W-1:0]  win_data;
    logic [SAMPLE_W-1:0]  sort_data;
    logic [SAMPLE_W-1:0]  median;
    logic [ACC_W-1:0]     acc;

    logic                 in_xfer;
    logic                 ch_ok;
    logic                 out_free;
    logic [ACC_W-Q_SHIFT-1:0] quot;
    logic [SAMPLE_W-1:0]  quot_sat;

    // Accept a new item only while idle
    assign in_ready = (state_reg == ST_IDLE);

    assign in_xfer  = in_valid && in_ready;
    assign ch_ok    = (channel == CH_BANK1) || (channel == CH_BANK2);
    assign out_free = !out_valid_reg || out_ready;

    // Saturate the final quotient
    assign quot     = acc[ACC_W-1:Q_SHIFT];
    assign quot_sat = (|quot[ACC_W-Q_SHIFT-1:SAMPLE_W]) ? '1 : quot[SAMPLE_W-1:0];

    mmbf_window_bank u_window (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (win_ctrl),
        .sample_in (sample),
        .rd_data   (win_data)
    );

    mmbf_sort_array u_sort (
        .clk         (clk),
        .ctrl        (sort_ctrl),
        .insert_data (win_data),
        .rd_data     (sort_data),
        .median      (median)
    );

    mmbf_arith_unit u_arith (
        .clk (clk),
        .cmd (arith_cmd),
        .acc (acc)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    state_next = ch_ok ? ST_SORT : ST_FINISH;
                end
            end
            ST_SORT:
            begin
                if (idx_reg == IDX_W'(WINDOW - 1))
                begin
                    state_next = ST_SUM;
                end
            end
            ST_SUM:
            begin
                if (idx_reg == IDX_W'(WINDOW - TRIM_EFF - 1))
                begin
                    state_next = ST_MEAN;
                end
            end
            ST_MEAN:   state_next = ST_WMEAN;
            ST_WMEAN:  state_next = ST_WMED;
            ST_WMED:   state_next = ST_QUOT;
            ST_QUOT:   state_next = ST_FINISH;
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // Sort control: clear on transfer, insert while sorting
    always_comb
    begin
        sort_ctrl.init      = in_xfer;
        sort_ctrl.insert_en = (state_reg == ST_SORT);
        sort_ctrl.rd_idx    = idx_reg;
    end

    // Datapath control per state
    always_comb
    begin
        idx_next            = idx_reg;
        bank_next           = bank_reg;
        zero_next           = zero_reg;
        out_valid_next      = out_valid_reg && !out_ready;
        filtered_next       = filtered_reg;
        win_ctrl.shift_en   = 1'b0;
        win_ctrl.shift_bank = (channel == CH_BANK2);
        win_ctrl.rd_bank    = bank_reg;
        win_ctrl.rd_idx     = idx_reg;
        arith_cmd.op        = OP_HOLD;
        arith_cmd.opa       = '0;
        arith_cmd.opb       = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    idx_next          = '0;
                    bank_next         = (channel == CH_BANK2);
                    zero_next         = !ch_ok;
                    win_ctrl.shift_en = ch_ok;
                    arith_cmd.op      = OP_CLR;
                end
            end
            ST_SORT:
            begin
                // Insert one window entry per cycle
                if (idx_reg == IDX_W'(WINDOW - 1))
                begin
                    idx_next = IDX_W'(TRIM_EFF);
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_SUM:
            begin
                // Accumulate the kept middle of the sorted window
                arith_cmd.op  = OP_ADD;
                arith_cmd.opa = MUL_W'(sort_data);
                idx_next      = idx_reg + 1'b1;
            end
            ST_MEAN:
            begin
                arith_cmd.op  = OP_MUL;
                arith_cmd.opa = MUL_W'(acc[SUM_W-1:0]);
                arith_cmd.opb = MEAN_RECIP;
            end
            ST_WMEAN:
            begin
                arith_cmd.op  = OP_MUL;
                arith_cmd.opa = MUL_W'(acc[MEAN_SHIFT +: SAMPLE_W]);
                arith_cmd.opb = MUL_W'(mean_weight_reg);
            end
            ST_WMED:
            begin
                arith_cmd.op  = OP_MAC;
                arith_cmd.opa = MUL_W'(median);
                arith_cmd.opb = MUL_W'(median_weight_reg);
            end
            ST_QUOT:
            begin
                arith_cmd.op  = OP_MUL;
                arith_cmd.opa = MUL_W'(acc[BLEND_W-1:0]);
                arith_cmd.opb = Q_RECIP;
            end
            ST_FINISH:
            begin
                // Hold until the output register is free
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    filtered_next  = zero_reg ? '0 : quot_sat;
                end
            end
            default:
            begin
                idx_next = '0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            bank_reg      <= 1'b0;
            zero_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            bank_reg      <= bank_next;
            zero_reg      <= zero_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        filtered_reg <= filtered_next;
    end

    // Weight registers; writes to unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mean_weight_reg   <= WEIGHT_RESET;
            median_weight_reg <= WEIGHT_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_MEAN_WEIGHT)
            begin
                mean_weight_reg <= cfg_data;
            end
            else if (cfg_index == REG_MEDIAN_WEIGHT)
            begin
                median_weight_reg <= cfg_data;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign filtered  = filtered_reg;

endmodule

>>> verif/median_mean_blend_filter_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for the two-bank median / trimmed-mean blend filter.
module median_mean_blend_filter_test;
    import mmbf_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int TAIL_CYCLES = 40;
    localparam int LONG_HOLD   = 400;
    localparam int PHASE_ITEMS = 150;
    localparam int NUM_PHASES  = 10;
    // Trim per end, pulled in so at least one entry survives into the average
    localparam int TRIM_CUT = (2 * TRIM >= WINDOW) ? (WINDOW - 1) / 2 : TRIM;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_A = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_B = CFG_IDX_W'(3);
    localparam logic [CH_W-1:0] CH_IGNORED_LO = CH_W'(0);
    localparam logic [CH_W-1:0] CH_IGNORED_HI = CH_W'(3);

    typedef struct {
        logic [SAMPLE_W-1:0] value;
        logic [CH_W-1:0]     bank;
    } reading_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic [SAMPLE_W-1:0]  sample = '0;
    logic [CH_W-1:0]      channel = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic [SAMPLE_W-1:0]  filtered;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [WEIGHT_W-1:0]  cfg_data = '0;

    // Predictor state: both sample windows and the two weights
    logic [SAMPLE_W-1:0] windows [2][WINDOW] = '{default: '0};
    int unsigned         mean_wt = WEIGHT_RESET;
    int unsigned         median_wt = WEIGHT_RESET;

    reading_t            pending_q [$];
    logic [SAMPLE_W-1:0] filtered_q [$];
    reading_t            cur_item;
    int                  gap_left = 0;
    int                  burst_left = 1;
    int                  hold_asked = 0;
    int                  hold_done = 0;
    int                  hold_left = 0;
    int                  pattern_age = 0;
    logic [7:0]          ready_pattern = 8'hFF;
    int                  fail_count = 0;
    int                  cycle_count = 0;

    median_mean_blend_filter u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .sample    (sample),
        .channel   (channel),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .filtered  (filtered),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Shift a reading into its bank and compute the blended output
    function automatic logic [SAMPLE_W-1:0] shift_and_blend(input logic [SAMPLE_W-1:0] value,
                                                            input logic [CH_W-1:0] bank);
        logic [SAMPLE_W-1:0] ordered [WINDOW];
        logic [SAMPLE_W-1:0] v;
        int                  b;
        int                  j;
        int unsigned         acc;
        int unsigned         avg;
        int unsigned         mid;
        int unsigned         blend;
        if (bank != CH_BANK1 && bank != CH_BANK2)
            return '0;
        b = (bank == CH_BANK1) ? 0 : 1;
        for (int i = 0; i < WINDOW - 1; i++)
            windows[b][i] = windows[b][i + 1];
        windows[b][WINDOW - 1] = value;

        // Insertion sort on a copy
        ordered = windows[b];
        for (int i = 1; i < WINDOW; i++)
        begin
            v = ordered[i];
            j = i;
            while (j > 0 && ordered[j - 1] > v)
            begin
                ordered[j] = ordered[j - 1];
                j--;
            end
            ordered[j] = v;
        end

        acc = 0;
        for (int i = TRIM_CUT; i < WINDOW - TRIM_CUT; i++)
            acc += ordered[i];
        avg = acc / (WINDOW - 2 * TRIM_CUT);
        mid = ordered[WINDOW / 2];
        blend = (avg * mean_wt + mid * median_wt) / 100;
        return (blend > 65535) ? 16'hFFFF : 16'(blend);
    endfunction

    // Random reading: mostly live banks, values biased toward extremes and clusters
    function automatic reading_t make_reading();
        reading_t r;
        case ($urandom_range(0, 19))
            0:       r.bank = CH_IGNORED_LO;
            1:       r.bank = CH_IGNORED_HI;
            default: r.bank = $urandom_range(0, 1) ? CH_BANK2 : CH_BANK1;
        endcase
        case ($urandom_range(0, 9))
            0:       r.value = 16'h0000;
            1:       r.value = 16'hFFFF;
            2:       r.value = 16'h8000 + 16'($urandom_range(0, 15));
            3:       r.value = 16'($urandom_range(0, 255));
            4:       r.value = 16'($urandom_range(16'hFF00, 16'hFFFF));
            default: r.value = 16'($urandom);
        endcase
        return r;
    endfunction

    task automatic queue_reading(input logic [SAMPLE_W-1:0] value, input logic [CH_W-1:0] bank);
        reading_t r;
        r.value = value;
        r.bank = bank;
        pending_q.push_back(r);
    endtask

    task automatic write_weight(input logic [CFG_IDX_W-1:0] idx, input logic [WEIGHT_W-1:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_MEAN_WEIGHT)
            mean_wt = val;
        else if (idx == REG_MEDIAN_WEIGHT)
            median_wt = val;
    endtask

    // Hold until every queued reading is sent and every result is back
    task automatic wait_idle();
        do
            @(negedge clk);
        while (pending_q.size() != 0 || in_valid || filtered_q.size() != 0);
    endtask

    // Sender: bursts of transfers separated by random gaps
    always @(posedge clk)
    begin
        logic offering;
        if (in_valid && in_ready)
            filtered_q.push_back(shift_and_blend(cur_item.value, cur_item.bank));
        offering = in_valid && !in_ready;
        if (!offering)
        begin
            if (gap_left > 0)
                gap_left--;
            else if (pending_q.size() > 0)
            begin
                cur_item = pending_q.pop_front();
                sample <= cur_item.value;
                channel <= cur_item.bank;
                offering = 1'b1;
                burst_left--;
                if (burst_left <= 0)
                begin
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
                    burst_left = $urandom_range(1, 16);
                end
            end
        end
        in_valid <= offering;
    end

    // Receiver: check each transfer, then pick the next ready from a rotating pattern
    always @(posedge clk)
    begin
        if (out_valid && out_ready)
        begin
            if (filtered_q.size() == 0)
            begin
                $error("filtered: no result pending, got %0d", filtered);
                fail_count++;
            end
            else if (filtered !== filtered_q[0])
            begin
                $error("filtered mismatch: expected %0d, actual %0d", filtered_q[0], filtered);
                fail_count++;
                void'(filtered_q.pop_front());
            end
            else
                void'(filtered_q.pop_front());
        end

        if (hold_done != hold_asked)
        begin
            hold_left = LONG_HOLD;
            hold_done++;
        end
        if (pattern_age == 0)
        begin
            case ($urandom_range(0, 3))
                0:       ready_pattern = 8'hFF;
                1:       ready_pattern = 8'($urandom) | 8'h01;
                2:       ready_pattern = 8'h11;
                default: ready_pattern = 8'hFE;
            endcase
            pattern_age = $urandom_range(16, 96);
        end
        else
            pattern_age--;
        ready_pattern = {ready_pattern[6:0], ready_pattern[7]};
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ready_pattern[0];
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin
        logic [WEIGHT_W-1:0] w_mean;
        logic [WEIGHT_W-1:0] w_median;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: ignored channels, extremes on both banks at reset weights
        queue_reading(16'hFFFF, CH_IGNORED_LO);
        queue_reading(16'hA5A5, CH_IGNORED_HI);
        queue_reading(16'hFFFF, CH_BANK1);
        queue_reading(16'h0000, CH_BANK2);
        queue_reading(16'h8000, CH_BANK1);
        queue_reading(16'h0001, CH_BANK2);
        queue_reading(16'hFFFF, CH_BANK2);
        queue_reading(16'h7FFF, CH_BANK1);
        queue_reading(16'h1234, CH_BANK1);
        queue_reading(16'hFFFF, CH_BANK1);
        queue_reading(16'h5A5A, CH_BANK2);
        queue_reading(16'h0000, CH_BANK1);
        wait_idle();

        // Directed: writes past the last register, then weights above 100 to saturate
        write_weight(REG_UNUSED_A, 7'h7F);
        write_weight(REG_UNUSED_B, 7'h7F);
        write_weight(REG_MEAN_WEIGHT, 7'd127);
        write_weight(REG_MEDIAN_WEIGHT, 7'd127);
        for (int i = 0; i < 8; i++)
            queue_reading(16'hFFFF, CH_BANK1);
        queue_reading(16'hFFFF, CH_BANK2);
        queue_reading(16'h0000, CH_IGNORED_HI);
        wait_idle();

        // Random phases, each at its own weight setting
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            case (p)
                0:       begin w_mean = 7'd0;   w_median = 7'd0;   end
                1:       begin w_mean = 7'd100; w_median = 7'd0;   end
                2:       begin w_mean = 7'd0;   w_median = 7'd100; end
                3:       begin w_mean = 7'd100; w_median = 7'd100; end
                4:       begin w_mean = 7'd127; w_median = 7'd127; end
                5:       begin w_mean = 7'd127; w_median = 7'd0;   end
                6:       begin w_mean = 7'd0;   w_median = 7'd127; end
                7:       begin w_mean = 7'd1;   w_median = 7'd99;  end
                default:
                begin
                    w_mean = 7'($urandom_range(0, 127));
                    w_median = 7'($urandom_range(0, 127));
                end
            endcase
            write_weight(REG_MEAN_WEIGHT, w_mean);
            write_weight(REG_MEDIAN_WEIGHT, w_median);
            if (p % 3 == 0)
                write_weight(($urandom_range(0, 1) ? REG_UNUSED_A : REG_UNUSED_B),
                             7'($urandom));
            // Starve the output for a long stretch while readings keep coming
            if (p == 3)
                hold_asked++;
            for (int n = 0; n < PHASE_ITEMS; n++)
                pending_q.push_back(make_reading());
            wait_idle();
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0 && filtered_q.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
